FILE: hdl/nvmeqp_pkg.sv
// Types and constants shared by the NVMe queue pair engine.
// No dependencies.
package nvmeqp_pkg;

	localparam int unsigned PTR_W    = 6;
	localparam int unsigned CID_W    = 16;
	localparam int unsigned OFFSET_W = 19;
	localparam int unsigned SC_W     = 15;
	localparam int unsigned STRIDE_W = 4;

	localparam logic [OFFSET_W-1:0] DB_BASE = 19'h01000;
	localparam logic [SC_W-1:0]     SC_MASK = 15'h7FFF;

	localparam logic FUNC_SUBMIT   = 1'b0;
	localparam logic FUNC_COMPLETE = 1'b1;

	localparam logic QUEUE_ADMIN = 1'b0;
	localparam logic QUEUE_IO    = 1'b1;

	typedef struct packed {
		logic        func;
		logic        queue_sel;
		logic [15:0] cqe_status;
	} cmd_t;

	typedef struct packed {
		logic [PTR_W-1:0]    slot;
		logic [CID_W-1:0]    command_id;
		logic                consumed;
		logic                doorbell_write;
		logic [OFFSET_W-1:0] doorbell_offset;
		logic [PTR_W-1:0]    doorbell_value;
		logic [SC_W-1:0]     status_code;
		logic                failed;
	} rsp_t;

endpackage

FILE: hdl/nvme_queue_pair_engine.sv
// Top level of the NVMe queue pair engine: admin and I/O submission tails,
// completion heads, phase tags and the shared command identifier counter.
// Depends on nvmeqp_pkg.

// The engine takes one transaction per clock while cmd_stall is low and returns
// exactly one result for each: the transaction is captured in an input register,
// the slot, identifier, pointer update and doorbell offset are formed
// combinationally against the current queue state, and the result is held in an
// output register until taken. The queue state is updated in the same cycle the
// result is formed, so back-to-back transactions on the same queue see each
// other. cmd_stall rises only while both registers are full and rsp_stall is
// high. The doorbell stride register is written through cfg_valid/cfg_ready,
// always ready, and must only change while no transaction is in flight.
module nvme_queue_pair_engine
	import nvmeqp_pkg::*;
#(
	parameter int unsigned ADMIN_DEPTH = 64,
	parameter int unsigned IO_DEPTH    = 64
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [STRIDE_W-1:0] cfg_data,

	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  cmd_t                cmd,

	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_t                rsp
);

	localparam logic [PTR_W-1:0] ADMIN_LAST = PTR_W'(ADMIN_DEPTH - 1);
	localparam logic [PTR_W-1:0] IO_LAST    = PTR_W'(IO_DEPTH - 1);

	logic [STRIDE_W-1:0] stride_q;
	logic [PTR_W-1:0]    admin_tail_q;
	logic [PTR_W-1:0]    admin_head_q;
	logic                admin_phase_q;
	logic [PTR_W-1:0]    io_tail_q;
	logic [PTR_W-1:0]    io_head_q;
	logic                io_phase_q;
	logic [CID_W-1:0]    cid_q;

	logic                valid_s1;
	cmd_t                item_s1;
	logic                valid_s2;
	rsp_t                rsp_s2;

	logic                stall_s1;
	logic                advance_s1;
	logic                is_submit;
	logic                q_io;
	logic [PTR_W-1:0]    ptr_cur;
	logic [PTR_W-1:0]    ptr_last;
	logic [PTR_W-1:0]    ptr_next;
	logic                phase_cur;
	logic                match;
	logic [4:0]          shift_amt;
	logic [OFFSET_W-1:0] db_off;
	logic                take;
	rsp_t                rsp_next;

	assign cfg_ready  = 1'b1;
	assign stall_s1   = valid_s1 && valid_s2 && rsp_stall;
	assign advance_s1 = valid_s1 && !stall_s1;
	assign cmd_stall  = stall_s1;
	assign rsp_valid  = valid_s2;
	assign rsp        = rsp_s2;

	always_comb begin
		is_submit = (item_s1.func == FUNC_SUBMIT);
		q_io      = (item_s1.queue_sel == QUEUE_IO);
		ptr_last  = q_io ? IO_LAST : ADMIN_LAST;
		phase_cur = q_io ? io_phase_q : admin_phase_q;
		if (is_submit) begin
			ptr_cur = q_io ? io_tail_q : admin_tail_q;
		end else begin
			ptr_cur = q_io ? io_head_q : admin_head_q;
		end
		ptr_next  = (ptr_cur == ptr_last) ? '0 : ptr_cur + PTR_W'(1);
		match     = (item_s1.cqe_status[0] == phase_cur);
		take      = is_submit || match;
		shift_amt = {1'b0, stride_q} + 5'd2;
		db_off    = DB_BASE + (OFFSET_W'({item_s1.queue_sel, item_s1.func}) << shift_amt);

		rsp_next                 = '0;
		rsp_next.slot            = ptr_cur;
		if (is_submit) begin
			rsp_next.command_id = cid_q;
		end
		if (take) begin
			rsp_next.consumed        = 1'b1;
			rsp_next.doorbell_write  = 1'b1;
			rsp_next.doorbell_offset = db_off;
			rsp_next.doorbell_value  = ptr_next;
			if (!is_submit) begin
				rsp_next.status_code = item_s1.cqe_status[SC_W:1] & SC_MASK;
				rsp_next.failed      = (item_s1.cqe_status[SC_W:1] != '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			stride_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			admin_tail_q  <= '0;
			admin_head_q  <= '0;
			admin_phase_q <= 1'b1;
			io_tail_q     <= '0;
			io_head_q     <= '0;
			io_phase_q    <= 1'b1;
			cid_q         <= CID_W'(1);
		end else if (advance_s1) begin
			if (is_submit) begin
				cid_q <= cid_q + CID_W'(1);
				if (q_io) begin
					io_tail_q <= ptr_next;
				end else begin
					admin_tail_q <= ptr_next;
				end
			end else if (match) begin
				if (q_io) begin
					io_head_q <= ptr_next;
					if (ptr_next == '0) begin
						io_phase_q <= ~io_phase_q;
					end
				end else begin
					admin_head_q <= ptr_next;
					if (ptr_next == '0) begin
						admin_phase_q <= ~admin_phase_q;
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && valid_s2 && rsp_stall))
		else $error("input stalled while a register is free");

	a_cid_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && is_submit) |=> (cid_q == $past(cid_q) + CID_W'(1)))
		else $error("command identifier did not advance on submit");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance_s1 |=> ($stable(admin_tail_q) && $stable(admin_head_q) &&
			$stable(io_tail_q) && $stable(io_head_q) && $stable(cid_q)))
		else $error("queue state changed without a transaction");

	a_mismatch_not_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && !is_submit && !match) |=> (valid_s2 && !rsp_s2.consumed))
		else $error("completion with wrong phase was consumed");

	a_pointers_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(admin_tail_q <= ADMIN_LAST) && (admin_head_q <= ADMIN_LAST) &&
		(io_tail_q <= IO_LAST) && (io_head_q <= IO_LAST))
		else $error("queue pointer beyond depth");
`endif

endmodule

FILE: bench/tb_nvme_queue_pair_engine.sv
`timescale 1ns / 1ps
// Self-checking bench for nvme_queue_pair_engine: a scoreboard class that predicts
// tails, heads, phase tags and command identifiers, and tasks that drive cmd and cfg.
// Depends on nvmeqp_pkg and the engine RTL.
module tb_nvme_queue_pair_engine
	import nvmeqp_pkg::*;
;

	localparam int ADMIN_DEPTH_TB = 64;
	localparam int IO_DEPTH_TB    = 64;

	class qp_scoreboard;
		logic [PTR_W-1:0]    sub_tail[2];
		logic [PTR_W-1:0]    comp_head[2];
		logic                phase[2];
		logic [CID_W-1:0]    issue_cid;
		logic [STRIDE_W-1:0] stride_log2;
		rsp_t                pending_rsps[$];
		int errors, n_submits, n_consumed, n_stale, n_failed, n_flips, n_cid_wraps, n_rsps;

		function new();
			stride_log2 = '0;
			issue_cid = 16'd1;
			for (int q = 0; q < 2; q++) begin
				sub_tail[q] = '0;
				comp_head[q] = '0;
				phase[q] = 1'b1;
			end
		endfunction

		function logic [OFFSET_W-1:0] doorbell_at(int idx);
			logic [31:0] spacing;
			logic [31:0] off;
			spacing = 32'd4 << stride_log2;
			off = 32'(DB_BASE) + idx * spacing;
			return off[OFFSET_W-1:0];
		endfunction

		function void accept_cmd(cmd_t c);
			rsp_t r;
			int q;
			int depth;
			int nxt;
			r = '0;
			q = int'(c.queue_sel);
			depth = (c.queue_sel == QUEUE_IO) ? IO_DEPTH_TB : ADMIN_DEPTH_TB;
			if (c.func == FUNC_SUBMIT) begin
				r.slot = sub_tail[q];
				r.command_id = issue_cid;
				issue_cid = issue_cid + 16'd1;
				nxt = (int'(sub_tail[q]) + 1) % depth;
				sub_tail[q] = nxt[PTR_W-1:0];
				r.consumed = 1'b1;
				r.doorbell_write = 1'b1;
				r.doorbell_offset = doorbell_at(2 * q);
				r.doorbell_value = sub_tail[q];
				n_submits++;
				if (r.command_id == '0) n_cid_wraps++;
			end else begin
				r.slot = comp_head[q];
				if (c.cqe_status[0] == phase[q]) begin
					nxt = (int'(comp_head[q]) + 1) % depth;
					comp_head[q] = nxt[PTR_W-1:0];
					if (nxt == 0) begin
						phase[q] = ~phase[q];
						n_flips++;
					end
					r.consumed = 1'b1;
					r.doorbell_write = 1'b1;
					r.doorbell_offset = doorbell_at(2 * q + 1);
					r.doorbell_value = comp_head[q];
					r.status_code = c.cqe_status[15:1] & SC_MASK;
					r.failed = |r.status_code;
					n_consumed++;
					if (r.failed) n_failed++;
				end else begin
					n_stale++;
				end
			end
			pending_rsps.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] exp, logic [31:0] act);
			if (act !== exp) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
				errors++;
			end
		endfunction

		function void check_rsp(rsp_t r);
			rsp_t e;
			n_rsps++;
			if (pending_rsps.size() == 0) begin
				$error("response with nothing outstanding: 0x%0h", r);
				errors++;
				return;
			end
			e = pending_rsps.pop_front();
			check_field("slot", 32'(e.slot), 32'(r.slot));
			check_field("command_id", 32'(e.command_id), 32'(r.command_id));
			check_field("consumed", 32'(e.consumed), 32'(r.consumed));
			check_field("doorbell_write", 32'(e.doorbell_write), 32'(r.doorbell_write));
			check_field("doorbell_offset", 32'(e.doorbell_offset), 32'(r.doorbell_offset));
			check_field("doorbell_value", 32'(e.doorbell_value), 32'(r.doorbell_value));
			check_field("status_code", 32'(e.status_code), 32'(r.status_code));
			check_field("failed", 32'(e.failed), 32'(r.failed));
		endfunction

		function int pending();
			return pending_rsps.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [STRIDE_W-1:0] cfg_data = '0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	cmd_t                cmd = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp;

	qp_scoreboard sb = new();
	bit tx_calm, rx_calm;
	int n_strides;

	nvme_queue_pair_engine #(
		.ADMIN_DEPTH(ADMIN_DEPTH_TB),
		.IO_DEPTH   (IO_DEPTH_TB)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #4 clk = ~clk;

	task automatic push_cmd(input cmd_t c);
		int gap;
		if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		sb.accept_cmd(c);
	endtask

	task automatic push_fields(input logic func, input logic q, input logic [15:0] status);
		cmd_t c;
		c.func = func;
		c.queue_sel = q;
		c.cqe_status = status;
		push_cmd(c);
	endtask

	task automatic write_stride(input logic [STRIDE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.stride_log2 = value;
		n_strides++;
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic cmd_t pick_cmd();
		cmd_t c;
		logic [14:0] sc;
		logic tag;
		c.func = 1'($urandom_range(0, 1));
		c.queue_sel = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: sc = '0;
			1: sc = 15'h7FFF;
			2: sc = 15'd1 << $urandom_range(0, 14);
			default: sc = 15'($urandom_range(0, 32767));
		endcase
		tag = sb.phase[int'(c.queue_sel)];
		if (c.func == FUNC_SUBMIT || $urandom_range(0, 3) == 0) tag = 1'($urandom_range(0, 1));
		c.cqe_status = {sc, tag};
		return c;
	endfunction

	task automatic random_run(input int count);
		repeat (count) push_cmd(pick_cmd());
	endtask

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int hold;
			if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
			hold = rx_calm ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			sb.check_rsp(rsp);
		end
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int guard;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_stride(4'd15);
		push_fields(FUNC_SUBMIT, QUEUE_ADMIN, 16'h0000);
		push_fields(FUNC_SUBMIT, QUEUE_IO, 16'hFFFF);
		push_fields(FUNC_COMPLETE, QUEUE_ADMIN, 16'h0000);
		push_fields(FUNC_COMPLETE, QUEUE_ADMIN, 16'h0001);
		push_fields(FUNC_COMPLETE, QUEUE_ADMIN, 16'hFFFF);
		push_fields(FUNC_COMPLETE, QUEUE_IO, 16'hFFFE);
		push_fields(FUNC_COMPLETE, QUEUE_IO, 16'h0003);
		push_fields(FUNC_COMPLETE, QUEUE_IO, 16'h5555);
		push_fields(FUNC_COMPLETE, QUEUE_ADMIN, 16'hAAAB);
		push_fields(FUNC_COMPLETE, QUEUE_ADMIN, 16'hAAAA);
		push_fields(FUNC_SUBMIT, QUEUE_IO, 16'h5555);
		push_fields(FUNC_SUBMIT, QUEUE_IO, 16'hAAAA);
		push_fields(FUNC_SUBMIT, QUEUE_ADMIN, 16'hFFFF);
		push_fields(FUNC_COMPLETE, QUEUE_IO, 16'h0001);
		push_fields(FUNC_COMPLETE, QUEUE_IO, 16'h8000);
		push_fields(FUNC_COMPLETE, QUEUE_ADMIN, 16'h7FFE);
		settle();

		write_stride(4'd0);
		random_run(350);
		settle();

		write_stride(4'd15);
		random_run(350);
		settle();

		write_stride(4'($urandom_range(1, 14)));
		random_run(350);
		settle();

		write_stride(4'd7);
		random_run(350);

		cmd_valid <= 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		if (sb.pending() != 0) begin
			$error("%0d responses never arrived", sb.pending());
			sb.errors += sb.pending();
		end
		repeat (8) @(posedge clk);

		$display("Covered %0d submits (%0d identifier wraps), %0d completions consumed, %0d stale",
			sb.n_submits, sb.n_cid_wraps, sb.n_consumed, sb.n_stale);
		$display("  %0d with error status, %0d phase flips, %0d stride writes, %0d responses",
			sb.n_failed, sb.n_flips, n_strides, sb.n_rsps);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/nvmeqp_pkg.sv
hdl/nvme_queue_pair_engine.sv
bench/tb_nvme_queue_pair_engine.sv
